// ===== rtl/idf_pkg.sv =====
// Shared types and constants for the integer divide and flags unit.
package idf_pkg;

  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned BITS_PER_STAGE = 8;

  typedef enum logic [2:0] {
    FUNC_DIVU_L = 3'd0,
    FUNC_DIVU_LL = 3'd1,
    FUNC_DIVS_L = 3'd2,
    FUNC_DIVS_LL = 3'd3,
    FUNC_DIVU_W = 3'd4,
    FUNC_DIVS_W = 3'd5,
    FUNC_NOP6 = 3'd6,
    FUNC_NOP7 = 3'd7
  } func_t;

  // Per-request side information that travels next to the datapath.
  typedef struct packed {
    logic [2:0] func;
    logic [31:0] lo;
    logic [31:0] hi;
    logic sep;
    logic fn;
    logic fz;
    logic fv;
    logic fc;
    logic dz;
    logic qneg;
    logic aneg;
  } idf_side_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [63:0] quo;
    logic [32:0] rem;
    logic [31:0] dmag;
  } idf_div_t;

endpackage

// ===== rtl/integer_divide_flags_unit.sv =====
// Top level: pipelined 64/32 integer divider with condition-code update.
//
//  channel | ports                     | direction
//  input   | in_valid / in_stall       | request in
//  output  | out_valid / out_stall     | result out
//
// One operand stage, eight divide stages of eight quotient bits each, and
// one result stage. A request may enter every cycle while in_stall is low.
// Reset clears all valid bits only. A stall on the output freezes the whole
// pipeline; in_stall is raised while the last stage holds an untaken result.
module integer_divide_flags_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_dividend_low,
  input  logic [31:0] in_dividend_high,
  input  logic [31:0] in_divisor,
  input  logic        in_separate_remainder,
  input  logic        in_flag_n_in,
  input  logic        in_flag_z_in,
  input  logic        in_flag_v_in,
  input  logic        in_flag_c_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_quotient_word,
  output logic [31:0] out_remainder_word,
  output logic        out_write_quotient,
  output logic        out_write_remainder,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_v,
  output logic        out_flag_c,
  output logic        out_divide_by_zero
);
  import idf_pkg::*;

  logic adv;
  logic [NUM_STAGES:0] vld_r;
  idf_side_t side_r [NUM_STAGES+1];
  idf_div_t  div_r  [NUM_STAGES+1];
  idf_div_t  div_nxt [NUM_STAGES];

  logic out_vld_r;
  logic [31:0] qw_r, rw_r;
  logic wq_r, wr_r, fn_r, fz_r, fv_r, fc_r, dz_r;

  // whole pipe moves when the output register is free or being taken
  assign adv = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  // operand preparation
  idf_side_t s0;
  idf_div_t d0;
  logic wide, sgn, word;
  logic [31:0] ah;
  logic [63:0] a, amag;
  logic [31:0] dvx, bmag;
  logic bneg;

  always_comb begin
    word = (in_func == FUNC_DIVU_W) || (in_func == FUNC_DIVS_W);
    wide = in_func[0] && !word;
    sgn = word ? (in_func == FUNC_DIVS_W) : in_func[1];
    if (word) begin
      ah = (sgn && in_dividend_low[31]) ? 32'hffff_ffff : 32'd0;
      dvx = sgn ? {{16{in_divisor[15]}}, in_divisor[15:0]} : {16'd0, in_divisor[15:0]};
    end else begin
      ah = wide ? in_dividend_high : ((sgn && in_dividend_low[31]) ? 32'hffff_ffff : 32'd0);
      dvx = in_divisor;
    end
    a = {ah, in_dividend_low};
    bneg = sgn && dvx[31];
    amag = (sgn && a[63]) ? (64'd0 - a) : a;
    bmag = bneg ? (32'd0 - dvx) : dvx;
    s0.func = in_func;
    s0.lo = in_dividend_low;
    s0.hi = in_dividend_high;
    s0.sep = in_separate_remainder;
    s0.fn = in_flag_n_in;
    s0.fz = in_flag_z_in;
    s0.fv = in_flag_v_in;
    s0.fc = in_flag_c_in;
    s0.dz = (dvx == 32'd0);
    s0.aneg = sgn && a[63];
    s0.qneg = sgn && (a[63] != bneg);
    d0.quo = amag;
    d0.rem = 33'd0;
    d0.dmag = bmag;
  end

  // divide stages: eight restoring steps each
  always_comb begin
    logic [32:0] rem;
    logic [63:0] quo;
    logic [33:0] t;
    for (int s = 0; s < NUM_STAGES; s++) begin
      rem = div_r[s].rem;
      quo = div_r[s].quo;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t = {rem, quo[63]} - {2'b00, div_r[s].dmag};
        if (!t[33]) begin
          rem = t[32:0];
        end else begin
          rem = {rem[31:0], quo[63]};
        end
        quo = {quo[62:0], !t[33]};
      end
      div_nxt[s].quo = quo;
      div_nxt[s].rem = rem;
      div_nxt[s].dmag = div_r[s].dmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s0;
      div_r[0] <= d0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        side_r[s+1] <= side_r[s];
        div_r[s+1] <= div_nxt[s];
      end
    end
  end

  // result formation
  idf_side_t sf;
  logic [63:0] qm, q;
  logic [31:0] rm, r;
  logic [31:0] qw_nxt, rw_nxt;
  logic wq_nxt, wr_nxt, fn_nxt, fz_nxt, fv_nxt, fc_nxt, dz_nxt;
  logic fault, fwide, fsgn, ovf;

  always_comb begin
    sf = side_r[NUM_STAGES];
    qm = div_r[NUM_STAGES].quo;
    rm = div_r[NUM_STAGES].rem[31:0];
    q = sf.qneg ? (64'd0 - qm) : qm;
    r = sf.aneg ? (32'd0 - rm) : rm;
    qw_nxt = '0;
    rw_nxt = '0;
    wq_nxt = 1'b0;
    wr_nxt = 1'b0;
    fn_nxt = sf.fn;
    fz_nxt = sf.fz;
    fv_nxt = sf.fv;
    fc_nxt = sf.fc;
    dz_nxt = 1'b0;
    fwide = sf.func[0];
    fsgn = sf.func[1];
    fault = 1'b0;
    ovf = 1'b0;
    unique case (sf.func)
      FUNC_DIVU_L, FUNC_DIVU_LL, FUNC_DIVS_L, FUNC_DIVS_LL: begin
        fc_nxt = 1'b0;
        wq_nxt = 1'b1;
        if (sf.dz) begin
          dz_nxt = 1'b1;
          fault = 1'b1;
        end else begin
          if (!fsgn) begin
            fn_nxt = qm[31];
            fault = (qm[63:32] != 32'd0);
          end else begin
            fn_nxt = sf.qneg && (qm != 64'd0);
            fault = sf.qneg ? (qm > 64'h8000_0000) : (qm > 64'h7fff_ffff);
          end
          fz_nxt = (qm == 64'd0);
          fv_nxt = fault;
        end
        if (fault) begin
          qw_nxt = sf.lo;
          if (fwide && sf.sep) begin
            wr_nxt = 1'b1;
            rw_nxt = sf.hi;
          end
        end else begin
          qw_nxt = q[31:0];
          if (sf.sep) begin
            wr_nxt = 1'b1;
            rw_nxt = r;
          end
        end
      end
      FUNC_DIVU_W, FUNC_DIVS_W: begin
        if (sf.dz) begin
          dz_nxt = 1'b1;
        end else begin
          fc_nxt = 1'b0;
          if (sf.func == FUNC_DIVU_W) begin
            ovf = (qm[31:16] != 16'd0);
            fn_nxt = (qm[31:15] != 17'd0);
          end else begin
            fn_nxt = sf.qneg && (qm != 64'd0);
            ovf = sf.qneg ? (qm > 64'h8000) : (qm > 64'h7fff);
          end
          fz_nxt = (qm == 64'd0);
          fv_nxt = ovf;
          if (!ovf) begin
            wq_nxt = 1'b1;
            qw_nxt = {r[15:0], q[15:0]};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qw_r <= qw_nxt;
      rw_r <= rw_nxt;
      wq_r <= wq_nxt;
      wr_r <= wr_nxt;
      fn_r <= fn_nxt;
      fz_r <= fz_nxt;
      fv_r <= fv_nxt;
      fc_r <= fc_nxt;
      dz_r <= dz_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_quotient_word = qw_r;
  assign out_remainder_word = rw_r;
  assign out_write_quotient = wq_r;
  assign out_write_remainder = wr_r;
  assign out_flag_n = fn_r;
  assign out_flag_z = fz_r;
  assign out_flag_v = fv_r;
  assign out_flag_c = fc_r;
  assign out_divide_by_zero = dz_r;

endmodule

// ===== bench/integer_divide_flags_unit_tb.sv =====
// Testbench for the integer divide and flags unit: random and directed divide requests.
`timescale 1ns / 1ps

module integer_divide_flags_unit_tb;
  import idf_pkg::*;

  typedef struct packed {
    logic [31:0] qw;
    logic [31:0] rw;
    logic wq;
    logic wr;
    logic fn;
    logic fz;
    logic fv;
    logic fc;
    logic dz;
  } div_result_t;

  class divide_scoreboard;
    div_result_t pending_results[$];
    int mismatches;
    int checked;

    function void note_request(logic [2:0] fc_code, logic [31:0] lo, logic [31:0] hi,
                               logic [31:0] dv, logic sep, logic [3:0] nzvc);
      div_result_t r;
      logic [63:0] a, q, rm64, amag, bmag, qm;
      logic [31:0] dy, q16, r16, am16, bm16, qm16, rm16;
      logic wide, sgn, fault, aneg, bneg, qneg, ovf;
      func_t f;
      r = '0;
      {r.fn, r.fz, r.fv, r.fc} = nzvc;
      f = func_t'(fc_code);
      if (f inside {FUNC_DIVU_L, FUNC_DIVU_LL, FUNC_DIVS_L, FUNC_DIVS_LL}) begin
        wide = fc_code[0];
        sgn = fc_code[1];
        a = {wide ? hi : ((sgn && lo[31]) ? 32'hffffffff : 32'h0), lo};
        r.fc = 1'b0;
        fault = 1'b0;
        q = '0;
        rm64 = '0;
        if (dv == 0) begin
          r.dz = 1'b1;
          fault = 1'b1;
        end else if (!sgn) begin
          q = a / {32'h0, dv};
          rm64 = a % {32'h0, dv};
          r.fn = q[31];
          r.fz = (q == 0);
          fault = (q > 64'hffffffff);
          r.fv = fault;
        end else begin
          aneg = a[63];
          bneg = dv[31];
          amag = aneg ? -a : a;
          bmag = bneg ? (64'h100000000 - {32'h0, dv}) : {32'h0, dv};
          qm = amag / bmag;
          rm64 = amag % bmag;
          qneg = aneg != bneg;
          r.fn = qneg && (qm != 0);
          r.fz = (qm == 0);
          fault = qneg ? (qm > 64'h80000000) : (qm > 64'h7fffffff);
          r.fv = fault;
          q = qneg ? -qm : qm;
          rm64 = aneg ? -rm64 : rm64;
        end
        r.wq = 1'b1;
        if (fault) begin
          r.qw = lo;
          if (wide && sep) begin
            r.wr = 1'b1;
            r.rw = hi;
          end
        end else begin
          r.qw = q[31:0];
          if (sep) begin
            r.wr = 1'b1;
            r.rw = rm64[31:0];
          end
        end
      end else if (f == FUNC_DIVU_W || f == FUNC_DIVS_W) begin
        dy = {16'h0, dv[15:0]};
        if (dy == 0) begin
          r.dz = 1'b1;
        end else begin
          r.fc = 1'b0;
          if (f == FUNC_DIVU_W) begin
            q16 = lo / dy;
            r16 = lo % dy;
            ovf = (q16[31:16] != 0);
            r.fn = (q16 >= 32'h8000);
            r.fz = (q16 == 0);
          end else begin
            aneg = lo[31];
            bneg = dy[15];
            am16 = aneg ? -lo : lo;
            bm16 = bneg ? (32'h10000 - dy) : dy;
            qm16 = am16 / bm16;
            rm16 = am16 % bm16;
            qneg = aneg != bneg;
            r.fn = qneg && (qm16 != 0);
            r.fz = (qm16 == 0);
            ovf = qneg ? (qm16 > 32'h8000) : (qm16 > 32'h7fff);
            q16 = qneg ? -qm16 : qm16;
            r16 = aneg ? -rm16 : rm16;
          end
          r.fv = ovf;
          if (!ovf) begin
            r.wq = 1'b1;
            r.qw = {r16[15:0], q16[15:0]};
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(div_result_t got);
      div_result_t exp_r;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp qw=%h rw=%h wq=%b wr=%b nzvc=%b%b%b%b dz=%b",
                   checked, exp_r.qw, exp_r.rw, exp_r.wq, exp_r.wr, exp_r.fn, exp_r.fz,
                   exp_r.fv, exp_r.fc, exp_r.dz);
        if (mismatches <= 10)
          $display("             got qw=%h rw=%h wq=%b wr=%b nzvc=%b%b%b%b dz=%b",
                   got.qw, got.rw, got.wq, got.wr, got.fn, got.fz, got.fv, got.fc,
                   got.dz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic [31:0] in_dividend_low = '0;
  logic [31:0] in_dividend_high = '0;
  logic [31:0] in_divisor = '0;
  logic in_separate_remainder = 1'b0;
  logic in_flag_n_in = 1'b0;
  logic in_flag_z_in = 1'b0;
  logic in_flag_v_in = 1'b0;
  logic in_flag_c_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_quotient_word, out_remainder_word;
  logic out_write_quotient, out_write_remainder;
  logic out_flag_n, out_flag_z, out_flag_v, out_flag_c, out_divide_by_zero;

  integer_divide_flags_unit uut (.*);

  divide_scoreboard sb = new();
  int sender_idle_pct = 37;
  int receiver_idle_pct = 54;
  int requests_sent = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Result side: random stall, check on every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_quotient_word, out_remainder_word, out_write_quotient,
                       out_write_remainder, out_flag_n, out_flag_z, out_flag_v,
                       out_flag_c, out_divide_by_zero});
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  task automatic send_request(logic [2:0] f, logic [31:0] lo, logic [31:0] hi,
                              logic [31:0] dv, logic sep, logic [3:0] nzvc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_dividend_low <= lo;
    in_dividend_high <= hi;
    in_divisor <= dv;
    in_separate_remainder <= sep;
    {in_flag_n_in, in_flag_z_in, in_flag_v_in, in_flag_c_in} <= nzvc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(f, lo, hi, dv, sep, nzvc);
    requests_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom_range(15);
      1: return 32'hffffffff - $urandom_range(15);
      2: return 32'h80000000 + $urandom_range(3) - 2;
      3: return $urandom_range(16'hffff);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] f;
    logic [31:0] lo, hi, dv;
    f = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    lo = pick_word();
    dv = pick_word();
    if ($urandom_range(9) == 0) dv = 0;
    if (f == FUNC_DIVU_W || f == FUNC_DIVS_W) begin
      if ($urandom_range(1)) dv[31:16] = 16'($urandom);
      if ($urandom_range(2) == 0) lo = lo >> $urandom_range(16);
    end
    // Keep most high words below the divisor, or sign-extended, so the quotient fits.
    hi = pick_word();
    if ($urandom_range(2) != 0) begin
      if (f == FUNC_DIVU_LL && dv != 0) hi = $urandom % dv;
      if (f == FUNC_DIVS_LL) hi = lo[31] ? 32'hffffffff : 32'h0;
    end
    send_request(f, lo, hi, dv, 1'($urandom), 4'($urandom));
  endtask

  task automatic drain(int extra);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, each operation, divide by zero, overflow, most negative by -1.
    send_request(FUNC_DIVU_L, 32'hffffffff, 32'h0, 32'h1, 1'b1, 4'b1111);
    send_request(FUNC_DIVU_L, 32'h0, 32'h0, 32'hffffffff, 1'b0, 4'b0000);
    send_request(FUNC_DIVU_LL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 4'b1010);
    send_request(FUNC_DIVU_LL, 32'h12345678, 32'h1, 32'h2, 1'b1, 4'b0101);
    send_request(FUNC_DIVU_LL, 32'h12345678, 32'h9, 32'h0, 1'b1, 4'b1110);
    send_request(FUNC_DIVS_L, 32'h80000000, 32'h0, 32'hffffffff, 1'b1, 4'b0000);
    send_request(FUNC_DIVS_L, 32'h80000000, 32'h0, 32'h1, 1'b1, 4'b0001);
    send_request(FUNC_DIVS_L, 32'hfffffff9, 32'h0, 32'h2, 1'b1, 4'b1111);
    send_request(FUNC_DIVS_L, 32'h7, 32'h0, 32'h0, 1'b0, 4'b1011);
    send_request(FUNC_DIVS_LL, 32'h0, 32'h80000000, 32'hffffffff, 1'b1, 4'b0000);
    send_request(FUNC_DIVS_LL, 32'h80000000, 32'hffffffff, 32'h1, 1'b1, 4'b0000);
    send_request(FUNC_DIVS_LL, 32'h0, 32'h40000000, 32'h3, 1'b0, 4'b0110);
    send_request(FUNC_DIVS_LL, 32'hfffffffd, 32'hffffffff, 32'h2, 1'b1, 4'b0010);
    send_request(FUNC_DIVU_W, 32'hffffffff, 32'h0, 32'hffff0001, 1'b0, 4'b1111);
    send_request(FUNC_DIVU_W, 32'h0000ffff, 32'h0, 32'h1, 1'b0, 4'b0000);
    send_request(FUNC_DIVU_W, 32'h00008000, 32'h0, 32'h1, 1'b0, 4'b0000);
    send_request(FUNC_DIVU_W, 32'h1234, 32'h0, 32'hffff0000, 1'b1, 4'b1111);
    send_request(FUNC_DIVS_W, 32'h80000000, 32'h0, 32'hffff, 1'b0, 4'b0000);
    send_request(FUNC_DIVS_W, 32'hffff8000, 32'h0, 32'hffff, 1'b0, 4'b0000);
    send_request(FUNC_DIVS_W, 32'hffff8000, 32'h0, 32'h1, 1'b0, 4'b0001);
    send_request(FUNC_DIVS_W, 32'hfffffff9, 32'h0, 32'h8002, 1'b0, 4'b1000);
    send_request(FUNC_DIVS_W, 32'h5, 32'h0, 32'h10000, 1'b0, 4'b0101);
    send_request(FUNC_NOP6, 32'hffffffff, 32'hffffffff, 32'h0, 1'b1, 4'b1010);
    send_request(FUNC_NOP7, 32'h1, 32'h1, 32'h1, 1'b1, 4'b0101);
    // Hold off until the pipeline has emptied.
    drain(0);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 54 : 0;
      receiver_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 37 : 0;
      repeat (510) send_random();
    end
    drain(20);

    $display("Sent %0d divide requests over all six forms plus unused codes,", requests_sent);
    $display("with zero divisors, overflow and stall phases; %0d results checked.", sb.checked);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("integer_divide_flags_unit_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_results.size());
      $display("integer_divide_flags_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("integer_divide_flags_unit_tb: FAIL");
    $finish;
  end

endmodule
